// ----- src/dtr_pkg.sv -----
// Package for the divider timer: widths, bus addresses, item codes,
// the prescaler period table and the shared step-unit result type.
// No dependencies.
package dtr_pkg;

  // Low bits of cycle_count that a tick uses (at most CYC_FIELD_W, 8).
  localparam int CYCLE_BITS = 8;
  localparam int CYC_FIELD_W = 8;
  localparam int CYC_W = (CYCLE_BITS < CYC_FIELD_W) ? CYCLE_BITS : CYC_FIELD_W;

  localparam int FUNC_W  = 2;
  localparam int ADDR_W  = 16;
  localparam int DATA_W  = 8;
  localparam int DIV_W   = 16;
  localparam int PRE_W   = 11;
  localparam int CTRL_W  = 3;
  localparam int DELAY_W = 3;

  // Item kinds.
  localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd2;

  // Register map.
  localparam logic [ADDR_W-1:0] ADDR_DIV  = 16'hFF04;
  localparam logic [ADDR_W-1:0] ADDR_TIMA = 16'hFF05;
  localparam logic [ADDR_W-1:0] ADDR_TMA  = 16'hFF06;
  localparam logic [ADDR_W-1:0] ADDR_TAC  = 16'hFF07;

  localparam logic [DATA_W-1:0]  UNMAPPED_DATA = 8'hFF;
  localparam logic [DATA_W-1:0]  TIMA_MAX      = 8'hFF;
  localparam logic [DELAY_W-1:0] RELOAD_CYCLES = 3'd4;
  localparam int                 CTRL_EN_BIT   = 2;

  // Prescaler period for the two select bits.
  function automatic logic [PRE_W-1:0] period_of(input logic [1:0] sel);
    logic [PRE_W-1:0] p;
    case (sel)
      2'd0:    p = 11'd1024;
      2'd1:    p = 11'd16;
      2'd2:    p = 11'd64;
      2'd3:    p = 11'd256;
      default: p = 11'd1024;
    endcase
    return p;
  endfunction

  // One step of the prescaler/counter unit.
  typedef struct packed {
    logic              hit;
    logic              wrap;
    logic [PRE_W-1:0]  acc_next;
    logic [DATA_W-1:0] timer_next;
  } dtr_step_t;

endpackage

// ----- src/dtr_if.sv -----
// Handshake interfaces for the divider timer: request and response channels.
// Depends on dtr_pkg.
interface dtr_req_if;
  logic                          valid;
  logic                          ready;
  logic [dtr_pkg::FUNC_W-1:0]    func;
  logic [dtr_pkg::ADDR_W-1:0]    address;
  logic [dtr_pkg::DATA_W-1:0]    write_data;
  logic [dtr_pkg::CYC_FIELD_W-1:0] cycle_count;

  modport source (output valid, func, address, write_data, cycle_count, input ready);
  modport sink   (input valid, func, address, write_data, cycle_count, output ready);
endinterface

interface dtr_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [dtr_pkg::DATA_W-1:0] read_data;
  logic                       timer_irq;

  modport source (output valid, read_data, timer_irq, input ready);
  modport sink   (input valid, read_data, timer_irq, output ready);
endinterface

// ----- src/divider_timer_with_reload.sv -----
// Top level of the divider timer with delayed modulo reload.
// Depends on dtr_pkg, dtr_if (dtr_req_if, dtr_rsp_if) and dtr_step_unit.
//
//  channel | dir | payload                                   | handshake
//  --------+-----+-------------------------------------------+-------------
//  req_i   | in  | func, address, write_data, cycle_count    | valid/ready
//  rsp_o   | out | read_data, timer_irq                      | valid/ready
//
// Reads, writes and idle-timer ticks go through accept, then finish,
// which loads the output register. An enabled tick runs the prescaler
// loop in between, one prescaler period per run step until less than a
// period is left; the single compare-subtract step unit sets each step.
// req_i.ready is high only in idle; a result waits in finish while the
// output register is held, so a stalled rsp_o holds off the next item.
// Reset clears divider, prescaler, counter, modulo, control and reload state.
module divider_timer_with_reload (
  input  logic      clk_i,
  input  logic      rst_ni,
  dtr_req_if.sink   req_i,
  dtr_rsp_if.source rsp_o
);
  import dtr_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;  // prescaler periods being counted
  localparam logic [1:0] ST_FIN  = 2'd2;  // result waits for output register

  logic [1:0]         state_q, state_d;
  logic [DIV_W-1:0]   div_q;
  logic [PRE_W-1:0]   pre_q;
  logic [DATA_W-1:0]  tima_q;
  logic [DATA_W-1:0]  tma_q;
  logic [CTRL_W-1:0]  tac_q;
  logic               pend_q;
  logic [DELAY_W-1:0] delay_q;

  // Result being built, and the output register.
  logic [DATA_W-1:0]  res_rd_q;
  logic               res_irq_q;
  logic               out_vld_q;
  logic [DATA_W-1:0]  out_rd_q;
  logic               out_irq_q;

  logic               accept;
  logic               out_free;
  logic [DATA_W-1:0]  cyc;
  logic [DATA_W-1:0]  rd_mux;
  logic [PRE_W-1:0]   period;
  logic               tac_en;
  dtr_step_t          step;

  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !out_vld_q || rsp_o.ready;
  assign cyc      = DATA_W'(req_i.cycle_count[CYC_W-1:0]);
  assign period   = period_of(tac_q[1:0]);
  assign tac_en   = tac_q[CTRL_EN_BIT];

  assign req_i.ready     = (state_q == ST_IDLE);
  assign rsp_o.valid     = out_vld_q;
  assign rsp_o.read_data = out_rd_q;
  assign rsp_o.timer_irq = out_irq_q;

  dtr_step_unit u_step (
    .acc_i    (pre_q),
    .period_i (period),
    .timer_i  (tima_q),
    .step_o   (step)
  );

  // Register read mux.
  always_comb begin
    case (req_i.address)
      ADDR_DIV:  rd_mux = div_q[DIV_W-1:DIV_W-DATA_W];
      ADDR_TIMA: rd_mux = tima_q;
      ADDR_TMA:  rd_mux = tma_q;
      ADDR_TAC:  rd_mux = DATA_W'(tac_q);
      default:   rd_mux = UNMAPPED_DATA;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_i.func == FUNC_TICK && tac_en) state_d = ST_RUN;
          else                                   state_d = ST_FIN;
        end
      end
      ST_RUN: begin
        if (!step.hit) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      div_q     <= '0;
      pre_q     <= '0;
      tima_q    <= '0;
      tma_q     <= '0;
      tac_q     <= '0;
      pend_q    <= 1'b0;
      delay_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (state_q == ST_IDLE && accept) begin
        case (req_i.func)
          FUNC_TICK: begin
            div_q <= div_q + DIV_W'(cyc);
            // Pending reload is settled before the prescaler runs.
            if (pend_q) begin
              if (cyc >= DATA_W'(delay_q)) begin
                pend_q  <= 1'b0;
                delay_q <= '0;
                tima_q  <= tma_q;
              end else begin
                delay_q <= delay_q - DELAY_W'(cyc);
              end
            end
            if (tac_en) pre_q <= pre_q + PRE_W'(cyc);
          end
          FUNC_WRITE: begin
            case (req_i.address)
              ADDR_DIV:  div_q <= '0;
              ADDR_TIMA: begin
                pend_q  <= 1'b0;   // write cancels a waiting reload
                delay_q <= '0;
                tima_q  <= req_i.write_data;
              end
              ADDR_TMA:  tma_q <= req_i.write_data;
              ADDR_TAC:  begin
                if (req_i.write_data[CTRL_W-1:0] != tac_q) pre_q <= '0;
                tac_q <= req_i.write_data[CTRL_W-1:0];
              end
              default: ;
            endcase
          end
          default: ;
        endcase
      end

      // One period per cycle; each wrap restarts the reload delay.
      if (state_q == ST_RUN && step.hit) begin
        pre_q <= step.acc_next;
        if (step.wrap) begin
          tima_q  <= '0;
          pend_q  <= 1'b1;
          delay_q <= RELOAD_CYCLES;
        end else begin
          tima_q  <= step.timer_next;
        end
      end

      if (state_q == ST_FIN && out_free) out_vld_q <= 1'b1;
      else if (rsp_o.ready)              out_vld_q <= 1'b0;
    end
  end

  // Result payload, no reset needed.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && accept) begin
      res_rd_q  <= (req_i.func == FUNC_READ) ? rd_mux : '0;
      res_irq_q <= (req_i.func == FUNC_TICK) && pend_q &&
                   (cyc >= DATA_W'(delay_q));
    end
    if (state_q == ST_FIN && out_free) begin
      out_rd_q  <= res_rd_q;
      out_irq_q <= res_irq_q;
    end
  end

  // Prescaler loop only runs while the timer is enabled.
  a_run_enabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> tac_en)
    else $error("prescaler loop running with timer disabled");

  // Outside a tick the prescaler holds less than one period.
  a_pre_below_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (pre_q < period))
    else $error("prescaler left at or above its period");

  // A waiting reload always has a nonzero delay of at most RELOAD_CYCLES.
  a_delay_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (delay_q != '0 && delay_q <= RELOAD_CYCLES))
    else $error("reload delay out of range while pending");

  // An interrupt result never carries read data.
  a_irq_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_irq_q) |-> (out_rd_q == '0))
    else $error("interrupt result with nonzero read data");

  // A result is loaded only from the finish state.
  a_load_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(out_vld_q)) |-> ($past(state_q) == ST_FIN))
    else $error("output loaded outside finish state");

endmodule

// ----- src/dtr_step_unit.sv -----
// Shared prescaler step: one compare-subtract against the period and one
// counter increment with wrap detect. Depends on dtr_pkg.
module dtr_step_unit (
  input  logic [dtr_pkg::PRE_W-1:0]  acc_i,
  input  logic [dtr_pkg::PRE_W-1:0]  period_i,
  input  logic [dtr_pkg::DATA_W-1:0] timer_i,
  output dtr_pkg::dtr_step_t         step_o
);
  import dtr_pkg::*;

  always_comb begin
    step_o.hit        = (acc_i >= period_i);
    step_o.acc_next   = acc_i - period_i;
    step_o.wrap       = (timer_i == TIMA_MAX);
    step_o.timer_next = timer_i + DATA_W'(1);
  end

endmodule

// ----- bench/divider_timer_with_reload_tb.sv -----
// Testbench for divider_timer_with_reload: directed register and tick items,
// then a random mix, each result checked against a built-in timer predictor.
// Depends on dtr_pkg, dtr_req_if, dtr_rsp_if and the RTL top level.
module divider_timer_with_reload_tb;
  import dtr_pkg::*;

  // Unused item kind: no state change, zero result.
  localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;

  // Control byte codes: enable bit plus period select.
  localparam logic [DATA_W-1:0] TAC_OFF     = 8'h00;
  localparam logic [DATA_W-1:0] TAC_EN_P16  = 8'h05;
  localparam logic [DATA_W-1:0] TAC_EN_P256 = 8'h07;

  localparam int RANDOM_ITEMS = 450;
  localparam int IDLE_PCT     = 24;
  localparam int QUIET_FROM   = 400;   // cycles with no idling on either side
  localparam int QUIET_TO     = 900;
  localparam int DRAIN_CYCLES = 40;    // > worst tick latency plus output stage
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_PRINTS   = 40;

  typedef struct packed {
    logic [FUNC_W-1:0]      func;
    logic [ADDR_W-1:0]      address;
    logic [DATA_W-1:0]      write_data;
    logic [CYC_FIELD_W-1:0] cycle_count;
  } bus_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              timer_irq;
  } bus_result_t;

  logic clk_i;
  logic rst_ni;

  dtr_req_if req_ch ();
  dtr_rsp_if rsp_ch ();

  divider_timer_with_reload dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  bus_item_t   pending_items[$];
  bus_result_t awaited_results[$];
  int          error_count;
  int          cycle_count;
  int          result_count;
  logic        req_taken;

  // Predicted timer state.
  logic [15:0]       div_cnt;
  int unsigned       pre_acc;
  logic [7:0]        tima;
  logic [7:0]        tma;
  logic [2:0]        tac;
  logic              reload_armed;
  int unsigned       reload_left;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Prescaler period picked by the two select bits.
  function automatic int unsigned prescale_period(input logic [1:0] sel);
    case (sel)
      2'd0:    return 1024;
      2'd1:    return 16;
      2'd2:    return 64;
      default: return 256;
    endcase
  endfunction

  // Advance the predicted timer by one accepted item; returns its result.
  function automatic bus_result_t timer_step(input bus_item_t it);
    bus_result_t res;
    int unsigned cyc;
    int unsigned period;
    res = '0;
    case (it.func)
      FUNC_TICK: begin
        cyc = int'(it.cycle_count) & ((1 << CYCLE_BITS) - 1);
        div_cnt = div_cnt + cyc[15:0];
        // A pending reload is settled before the prescaler runs, so the
        // same tick can both reload and wrap again.
        if (reload_armed) begin
          if (cyc >= reload_left) begin
            reload_armed = 1'b0;
            reload_left = 0;
            tima = tma;
            res.timer_irq = 1'b1;
          end else begin
            reload_left = reload_left - cyc;
          end
        end
        if (tac[CTRL_EN_BIT]) begin
          period = prescale_period(tac[1:0]);
          pre_acc = pre_acc + cyc;
          while (pre_acc >= period) begin
            pre_acc = pre_acc - period;
            if (tima == TIMA_MAX) begin
              tima = '0;
              reload_armed = 1'b1;
              reload_left = 4;
            end else begin
              tima = tima + 8'd1;
            end
          end
        end
      end
      FUNC_READ: begin
        case (it.address)
          ADDR_DIV:  res.read_data = div_cnt[15:8];
          ADDR_TIMA: res.read_data = tima;
          ADDR_TMA:  res.read_data = tma;
          ADDR_TAC:  res.read_data = {5'b0, tac};
          default:   res.read_data = UNMAPPED_DATA;
        endcase
      end
      FUNC_WRITE: begin
        case (it.address)
          ADDR_DIV:  div_cnt = '0;
          ADDR_TIMA: begin
            // counter write cancels a reload still in its delay
            reload_armed = 1'b0;
            reload_left = 0;
            tima = it.write_data;
          end
          ADDR_TMA:  tma = it.write_data;
          ADDR_TAC:  begin
            if (it.write_data[2:0] != tac) pre_acc = 0;
            tac = it.write_data[2:0];
          end
          default:   ;
        endcase
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTS)
      $display("ERROR @%0d cycles, result %0d: %s", cycle_count, result_count, msg);
  endtask

  task automatic add_item(input logic [FUNC_W-1:0] func, input logic [ADDR_W-1:0] addr,
                          input logic [DATA_W-1:0] data, input logic [CYC_FIELD_W-1:0] cyc);
    bus_item_t it;
    it.func = func;
    it.address = addr;
    it.write_data = data;
    it.cycle_count = cyc;
    pending_items.push_back(it);
  endtask

  // Random stall decision shared by both sides; a quiet window has none.
  function automatic bit idle_now();
    if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO) return 1'b0;
    return $urandom_range(99) < IDLE_PCT;
  endfunction

  function automatic logic [ADDR_W-1:0] pick_addr();
    case ($urandom_range(19))
      0, 1, 2: return ADDR_W'($urandom_range(65535));
      3, 4, 5, 6: return ADDR_DIV;
      7, 8, 9, 10, 11: return ADDR_TIMA;
      12, 13, 14, 15: return ADDR_TMA;
      default: return ADDR_TAC;
    endcase
  endfunction

  // Request driver: a valid item is held until taken, then the next one
  // is offered or the channel idles.
  always @(negedge clk_i) begin
    bus_item_t it;
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_taken) begin
      if (pending_items.size() > 0 && !idle_now()) begin
        it = pending_items.pop_front();
        req_ch.valid       <= 1'b1;
        req_ch.func        <= it.func;
        req_ch.address     <= it.address;
        req_ch.write_data  <= it.write_data;
        req_ch.cycle_count <= it.cycle_count;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Response back-pressure.
  always @(negedge clk_i) begin
    rsp_ch.ready <= rst_ni && !idle_now();
  end

  // Accept side feeds the predictor; result side checks in order.
  always @(posedge clk_i) begin
    bus_item_t   it;
    bus_result_t want;
    cycle_count <= cycle_count + 1;
    req_taken <= req_ch.valid && req_ch.ready;
    if (rst_ni && req_ch.valid && req_ch.ready) begin
      it.func        = req_ch.func;
      it.address     = req_ch.address;
      it.write_data  = req_ch.write_data;
      it.cycle_count = req_ch.cycle_count;
      awaited_results.push_back(timer_step(it));
    end
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      result_count <= result_count + 1;
      if (awaited_results.size() == 0) begin
        report_error("result with no item outstanding");
      end else begin
        want = awaited_results.pop_front();
        if (rsp_ch.read_data !== want.read_data)
          report_error($sformatf("read_data %h, expected %h",
                                 rsp_ch.read_data, want.read_data));
        if (rsp_ch.timer_irq !== want.timer_irq)
          report_error($sformatf("timer_irq %b, expected %b",
                                 rsp_ch.timer_irq, want.timer_irq));
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0] addr;
    int                kind;

    error_count  = 0;
    cycle_count  = 0;
    result_count = 0;
    req_taken    = 1'b0;
    div_cnt      = '0;
    pre_acc      = 0;
    tima         = '0;
    tma          = '0;
    tac          = '0;
    reload_armed = 1'b0;
    reload_left  = 0;

    rst_ni             = 1'b0;
    req_ch.valid       = 1'b0;
    req_ch.func        = FUNC_TICK;
    req_ch.address     = '0;
    req_ch.write_data  = '0;
    req_ch.cycle_count = '0;
    rsp_ch.ready       = 1'b0;

    // Directed: reset values, unmapped reads, wrap, delayed reload, counter
    // writes, control rewrites with and without change, divider clear and the
    // unused kind.
    add_item(FUNC_READ,  ADDR_DIV,  8'h00, 8'h00);
    add_item(FUNC_READ,  ADDR_TIMA, 8'h00, 8'h00);
    add_item(FUNC_READ,  ADDR_TMA,  8'h00, 8'h00);
    add_item(FUNC_READ,  ADDR_TAC,  8'h00, 8'h00);
    add_item(FUNC_READ,  16'h0000,  8'h00, 8'h00);
    add_item(FUNC_READ,  16'hFFFF,  8'h00, 8'h00);
    add_item(FUNC_WRITE, ADDR_TMA,  8'hFF, 8'h00);
    add_item(FUNC_WRITE, ADDR_TAC,  TAC_EN_P16, 8'h00);
    add_item(FUNC_WRITE, ADDR_TIMA, 8'hFF, 8'h00);
    add_item(FUNC_TICK,  16'h0000,  8'h00, 8'hFF);  // wrap, delay armed
    add_item(FUNC_TICK,  16'h0000,  8'h00, 8'h00);  // zero-cycle tick
    add_item(FUNC_TICK,  16'h0000,  8'h00, 8'h03);  // delay shortened, reload still waiting
    add_item(FUNC_TICK,  16'h0000,  8'h00, 8'h01);  // reload, irq
    add_item(FUNC_WRITE, ADDR_TIMA, 8'h00, 8'h00);  // counter write, no reload waiting
    add_item(FUNC_TICK,  16'h0000,  8'h00, 8'h08);
    add_item(FUNC_WRITE, ADDR_TAC,  TAC_EN_P16, 8'h00);   // same bits
    add_item(FUNC_WRITE, ADDR_TAC,  TAC_EN_P256, 8'h00);  // changed, clears
    add_item(FUNC_READ,  ADDR_TAC,  8'h00, 8'h00);
    add_item(FUNC_WRITE, ADDR_DIV,  8'h5A, 8'h00);
    add_item(FUNC_READ,  ADDR_DIV,  8'h00, 8'h00);
    add_item(FUNC_WRITE, 16'h1234,  8'hA5, 8'h00);
    add_item(FUNC_NOP,   16'hFFFF,  8'hFF, 8'hFF);
    add_item(FUNC_TICK,  16'hFFFF,  8'hFF, 8'hFF);
    add_item(FUNC_WRITE, ADDR_TAC,  TAC_OFF, 8'h00);
    add_item(FUNC_TICK,  16'h0000,  8'h00, 8'hC8);

    // Random mix: mostly ticks and register traffic, with counter writes
    // near the top and enabled control values so wraps and reloads recur.
    repeat (RANDOM_ITEMS) begin
      kind  = $urandom_range(99);
      addr  = pick_addr();
      wdata = DATA_W'($urandom_range(255));
      if (kind < 50) begin
        add_item(FUNC_TICK, ADDR_W'($urandom_range(65535)), wdata,
                 ($urandom_range(3) == 0) ? CYC_FIELD_W'($urandom_range(255))
                                          : CYC_FIELD_W'($urandom_range(40)));
      end else if (kind < 72) begin
        add_item(FUNC_READ, addr, wdata, CYC_FIELD_W'($urandom_range(255)));
      end else if (kind < 95) begin
        if (addr == ADDR_TIMA && $urandom_range(1))
          wdata = DATA_W'($urandom_range(240, 255));
        if (addr == ADDR_TAC && $urandom_range(9) < 7)
          wdata[2:0] = {1'b1, ($urandom_range(2) == 0) ? 2'd1 : 2'($urandom_range(3))};
        add_item(FUNC_WRITE, addr, wdata, CYC_FIELD_W'($urandom_range(255)));
      end else begin
        add_item(FUNC_NOP, ADDR_W'($urandom_range(65535)), wdata,
                 CYC_FIELD_W'($urandom_range(255)));
      end
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (pending_items.size() == 0 && !req_ch.valid && awaited_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0 && awaited_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      if (awaited_results.size() != 0)
        $display("ERROR: %0d results never arrived", awaited_results.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
